// ===== design/bofifo_pkg.sv =====
// Shared constants, types and helpers for the banked overwrite-oldest ring FIFO.
// No dependencies; every other design file refers to this package by scoped names.
package bofifo_pkg;

  localparam int CHANNELS  = 8;
  localparam int DEPTH     = 64;
  localparam int BANKS     = 2;
  localparam int RINGS     = BANKS * CHANNELS;
  localparam int RING_W    = $clog2(RINGS);
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int SLOT_W    = PTR_W + 1;
  localparam int MEM_DEPTH = RINGS * DEPTH;
  localparam int MEM_W     = $clog2(MEM_DEPTH);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [7:0] DASH = 8'h2D;

  // configuration register indexes
  localparam logic [1:0] CFG_IN_COUNT  = 2'd0;
  localparam logic [1:0] CFG_OUT_COUNT = 2'd1;
  localparam logic [1:0] CFG_SLOTS     = 2'd2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BAD_CH = 2'd2
  } status_t;

  typedef struct packed {
    logic              is_read;
    logic              bad;
    logic [RING_W-1:0] ring;
    logic [7:0]        value;
  } cmd_t;

  // step a ring pointer, wrapping at the effective slot count
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [SLOT_W-1:0] eff);
    logic [SLOT_W-1:0] n;
    n = {1'b0, p} + SLOT_W'(1);
    return (n >= eff) ? '0 : n[PTR_W-1:0];
  endfunction

endpackage

// ===== design/bofifo_front.sv =====
// Front end: configuration registers, input handshake and classification of beats.
// Depends on bofifo_pkg.
module bofifo_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [7:0]                      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_action,
  input  logic                            in_bank,
  input  logic [2:0]                      in_channel,
  input  logic [7:0]                      in_value,
  input  logic                            clear_done,
  output logic                            push_valid,
  input  logic                            push_ready,
  output bofifo_pkg::cmd_t                push_cmd,
  output logic [bofifo_pkg::SLOT_W-1:0]   eff_slots
);

  logic [3:0] in_cnt_r;
  logic [3:0] out_cnt_r;
  logic [6:0] slots_r;
  logic [3:0] limit;
  logic       bad;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r  <= 4'd8;
      out_cnt_r <= 4'd8;
      slots_r   <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        bofifo_pkg::CFG_IN_COUNT:  in_cnt_r  <= cfg_data[3:0];
        bofifo_pkg::CFG_OUT_COUNT: out_cnt_r <= cfg_data[3:0];
        bofifo_pkg::CFG_SLOTS:     slots_r   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // clamp slot count into [2, DEPTH]
  always_comb begin
    if (slots_r < 7'd2) begin
      eff_slots = bofifo_pkg::SLOT_W'(2);
    end else if (int'(slots_r) > bofifo_pkg::DEPTH) begin
      eff_slots = bofifo_pkg::SLOT_W'(bofifo_pkg::DEPTH);
    end else begin
      eff_slots = bofifo_pkg::SLOT_W'(slots_r);
    end
  end

  assign limit = in_bank ? out_cnt_r : in_cnt_r;
  assign bad   = ({1'b0, in_channel} >= limit) || (int'(in_channel) >= bofifo_pkg::CHANNELS);

  assign in_ready   = push_ready && clear_done;
  assign push_valid = in_valid && clear_done;

  always_comb begin
    push_cmd.is_read = in_action;
    push_cmd.bad     = bad;
    push_cmd.ring    = bofifo_pkg::RING_W'(int'(in_bank) * bofifo_pkg::CHANNELS
                                           + int'(in_channel));
    push_cmd.value   = in_value;
  end

endmodule

// ===== design/bofifo_queue.sv =====
// Short command queue between the front and back ends.
// Depends on bofifo_pkg for the command type and depth.
module bofifo_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  bofifo_pkg::cmd_t push_cmd,
  output logic             pop_valid,
  input  logic             pop,
  output bofifo_pkg::cmd_t pop_cmd
);

  bofifo_pkg::cmd_t                entry_r [bofifo_pkg::QDEPTH];
  logic [bofifo_pkg::QPTR_W-1:0]   wr_r;
  logic [bofifo_pkg::QPTR_W-1:0]   rd_r;
  logic [bofifo_pkg::QCNT_W-1:0]   cnt_r;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (int'(cnt_r) < bofifo_pkg::QDEPTH);
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = entry_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (int'(wr_r) == bofifo_pkg::QDEPTH - 1) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (int'(rd_r) == bofifo_pkg::QDEPTH - 1) ? '0 : rd_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_r] <= push_cmd;
    end
  end

endmodule

// ===== design/bofifo_back.sv =====
// Back end: ring pointers, slot memory with its post-reset clearing pass, result register.
// Depends on bofifo_pkg.
module bofifo_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  bofifo_pkg::cmd_t              q_cmd,
  input  logic [bofifo_pkg::SLOT_W-1:0] eff_slots,
  output logic                          clear_done,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_data,
  output logic [1:0]                    out_status,
  output logic                          out_dropped
);

  logic [7:0]                   mem [bofifo_pkg::MEM_DEPTH];
  logic [7:0]                   rdata_r;
  logic [bofifo_pkg::PTR_W-1:0] wp_r [bofifo_pkg::RINGS];
  logic [bofifo_pkg::PTR_W-1:0] rp_r [bofifo_pkg::RINGS];
  logic [bofifo_pkg::MEM_W-1:0] clr_r;
  logic                         clear_done_r;

  logic                         out_valid_r;
  bofifo_pkg::status_t          status_r;
  logic                         dropped_r;
  logic                         use_mem_r;

  logic                         exec;
  logic [bofifo_pkg::PTR_W-1:0] wp;
  logic [bofifo_pkg::PTR_W-1:0] rp;
  logic [bofifo_pkg::PTR_W-1:0] wp_nxt;
  logic [bofifo_pkg::PTR_W-1:0] rp_nxt;
  logic                         empty;
  logic                         drop;
  logic                         mem_we;
  logic                         mem_re;
  logic [bofifo_pkg::MEM_W-1:0] mem_addr;
  logic [7:0]                   mem_wdata;
  bofifo_pkg::status_t          status_nxt;

  assign exec = q_valid && clear_done_r && (!out_valid_r || out_ready);
  assign q_pop = exec;
  assign clear_done = clear_done_r;

  assign wp    = wp_r[q_cmd.ring];
  assign rp    = rp_r[q_cmd.ring];
  assign empty = (wp == rp);

  always_comb begin
    wp_nxt     = wp;
    rp_nxt     = rp;
    drop       = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wdata  = bofifo_pkg::DASH;
    status_nxt = bofifo_pkg::ST_OK;
    mem_addr   = bofifo_pkg::MEM_W'(int'(q_cmd.ring) * bofifo_pkg::DEPTH + int'(wp));
    if (!clear_done_r) begin
      mem_we   = 1'b1;
      mem_addr = clr_r;
    end else if (q_cmd.bad) begin
      status_nxt = bofifo_pkg::ST_BAD_CH;
    end else if (!q_cmd.is_read) begin
      mem_we    = exec;
      mem_wdata = q_cmd.value;
      wp_nxt    = bofifo_pkg::advance(wp, eff_slots);
      drop      = (wp_nxt == rp);
      if (drop) begin
        rp_nxt = bofifo_pkg::advance(rp, eff_slots);
      end
    end else if (empty) begin
      status_nxt = bofifo_pkg::ST_EMPTY;
    end else begin
      // fetch the oldest byte and blank its slot in the same beat
      mem_re   = exec;
      mem_we   = exec;
      mem_addr = bofifo_pkg::MEM_W'(int'(q_cmd.ring) * bofifo_pkg::DEPTH + int'(rp));
      rp_nxt   = bofifo_pkg::advance(rp, eff_slots);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r        <= '0;
      clear_done_r <= 1'b0;
    end else if (!clear_done_r) begin
      clr_r <= clr_r + 1'b1;
      if (int'(clr_r) == bofifo_pkg::MEM_DEPTH - 1) begin
        clear_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bofifo_pkg::RINGS; i++) begin
        wp_r[i] <= '0;
        rp_r[i] <= '0;
      end
    end else if (exec) begin
      wp_r[q_cmd.ring] <= wp_nxt;
      rp_r[q_cmd.ring] <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status_r  <= status_nxt;
      dropped_r <= drop;
      use_mem_r <= mem_re;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_data    = use_mem_r ? rdata_r : bofifo_pkg::DASH;
  assign out_status  = status_r;
  assign out_dropped = dropped_r;

  a_no_exec_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    !clear_done_r |-> !exec)
    else $error("command executed during clearing pass");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_valid_r)
    else $error("executed command left no result");

  a_drop_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dropped_r |-> status_r == bofifo_pkg::ST_OK && !use_mem_r)
    else $error("drop flagged on a failed access or a read");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(status_r))
    else $error("stalled result changed");

endmodule

// ===== design/banked_overwrite_ring_fifo.sv =====
// Top level of the banked overwrite-oldest ring FIFO: front end, command queue, back end.
// Depends on bofifo_pkg, bofifo_front, bofifo_queue and bofifo_back.
//
// Two banks of eight byte rings, each ring using slot_count slots (clamped to 2..64) and
// holding one byte fewer. A write beat stores the byte and, if the ring was full, drops
// the oldest byte and flags it; a read beat returns the oldest byte and blanks its slot
// with '-', or returns '-' with status empty. A channel at or beyond the bank's channel
// count returns status bad channel and changes nothing. Every input beat yields exactly
// one result beat, in order. After reset the slot memory is cleared to '-' one slot a
// cycle; in_ready stays low meanwhile, but configuration writes are taken throughout
// (cfg_ready is always high). Once cleared, the block sustains one beat per cycle while
// out_ready stays high: each beat makes a single access to the one-port slot memory, and
// the ring pointers sit in flip-flops updated in the same cycle. An accepted beat is first
// registered in the command queue, then executed into the result register that drives
// out_valid. Write configuration only while no beats are in flight.
module banked_overwrite_ring_fifo (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_action,
  input  logic       in_bank,
  input  logic [2:0] in_channel,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data,
  output logic [1:0] out_status,
  output logic       out_dropped
);

  // front end to queue
  logic                          push_valid;
  logic                          push_ready;
  bofifo_pkg::cmd_t              push_cmd;
  // queue to back end
  logic                          q_valid;
  logic                          q_pop;
  bofifo_pkg::cmd_t              q_cmd;
  // shared control
  logic [bofifo_pkg::SLOT_W-1:0] eff_slots;
  logic                          clear_done;

  // accept and classify beats, hold configuration
  bofifo_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_bank    (in_bank),
    .in_channel (in_channel),
    .in_value   (in_value),
    .clear_done (clear_done),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .eff_slots  (eff_slots)
  );

  // decouple the two ends so either may stall
  bofifo_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  // carry out ring accesses and drive the result beat
  bofifo_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_cmd       (q_cmd),
    .eff_slots   (eff_slots),
    .clear_done  (clear_done),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .out_status  (out_status),
    .out_dropped (out_dropped)
  );

endmodule
